FILE: rtl/qap_pkg.sv
package qap_pkg;

   localparam int MaxFacilities = 32;
   localparam int IdxBits = 5;
   localparam int AddrBits = 2 * IdxBits;
   localparam int EntryBits = 16;
   localparam int CostBits = 48;
   localparam int SizeBits = 9;
   localparam int ProdBits = 2 * EntryBits;

   localparam logic [2:0] MODE_WR_FLOW = 3'd0;
   localparam logic [2:0] MODE_WR_DIST = 3'd1;
   localparam logic [2:0] MODE_ASSIGN = 3'd2;
   localparam logic [2:0] MODE_EVAL = 3'd3;
   localparam logic [2:0] MODE_APPLY = 3'd4;
   localparam logic [2:0] MODE_RECOMP = 3'd5;

   // Term kinds, each one flow entry times the difference of two distances.
   localparam logic [2:0] TK_II = 3'd0;
   localparam logic [2:0] TK_JJ = 3'd1;
   localparam logic [2:0] TK_IJ = 3'd2;
   localparam logic [2:0] TK_JI = 3'd3;
   localparam logic [2:0] TK_IK = 3'd4;
   localparam logic [2:0] TK_KI = 3'd5;
   localparam logic [2:0] TK_JK = 3'd6;
   localparam logic [2:0] TK_KJ = 3'd7;

   typedef struct packed {
      logic                load;     // latch the request
      logic                wr_flow;
      logic                wr_dist;
      logic                wr_loc;
      logic                swap_loc;
      logic                clr_acc;
      logic                issue;    // issue a read for a term
      logic                full_term; // full-cost term (one product)
      logic [2:0]          kind;
      logic [IdxBits-1:0]  k;
      logic [IdxBits-1:0]  k2;
      logic                add_delta; // add delta to running cost
      logic                set_cost;  // running cost takes accumulator
      logic                emit;
      logic                bad;
      logic                zero_delta;
   } cmd_type;

   typedef struct packed {
      logic [2:0]          mode;
      logic                out_of_range;
      logic                rsp_busy;
      logic                pipe_empty;
      logic [IdxBits-1:0]  first;
      logic [IdxBits-1:0]  second;
      logic [IdxBits:0]    live_n;
   } status_type;

endpackage

FILE: rtl/qap_datapath.sv
module qap_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  qap_pkg::cmd_type                  cmd,
   output qap_pkg::status_type               stat,
   input  logic [2:0]                        req_mode,
   input  logic [7:0]                        req_first_index,
   input  logic [7:0]                        req_second_index,
   input  logic [15:0]                       req_entry_value,
   input  logic [qap_pkg::SizeBits-1:0]      size_ff,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic signed [47:0]                rsp_cost_delta,
   output logic [47:0]                       rsp_total_cost,
   output logic                              rsp_status
);

   localparam int IB = qap_pkg::IdxBits;
   localparam int AB = qap_pkg::AddrBits;
   localparam int EB = qap_pkg::EntryBits;
   localparam int CB = qap_pkg::CostBits;
   localparam int PB = qap_pkg::ProdBits;

   logic [EB-1:0] flow_mem [qap_pkg::MaxFacilities * qap_pkg::MaxFacilities];
   logic [EB-1:0] dist_mem_a [qap_pkg::MaxFacilities * qap_pkg::MaxFacilities];
   logic [EB-1:0] dist_mem_b [qap_pkg::MaxFacilities * qap_pkg::MaxFacilities];

   logic [IB-1:0] loc_ff [qap_pkg::MaxFacilities];
   logic [IB-1:0] loc_in [qap_pkg::MaxFacilities];

   logic [2:0]    mode_ff;
   logic [IB-1:0] a_ff, b_ff;
   logic [EB-1:0] val_ff;
   logic          oor_ff;
   logic [IB:0]   n_w;

   logic [CB-1:0] cost_ff, cost_in;
   logic [CB-1:0] acc_ff, acc_in;

   // Read stage: addresses registered into memory reads.
   logic          rd_v_ff;
   logic          rd_full_ff;
   logic [EB-1:0] f_q, da_q, db_q;
   // Multiply stage.
   logic          mul_v_ff;
   logic          mul_full_ff;
   logic [PB-1:0] pa_ff, pb_ff;

   logic          rsp_valid_ff;
   logic [CB-1:0] rsp_delta_ff;
   logic [CB-1:0] rsp_cost_ff;
   logic          rsp_status_ff;

   logic [IB-1:0] ai, bi, li, lj, lk, lk2;
   logic [AB-1:0] fa, da_a, db_a;

   always_comb begin
      n_w = (size_ff > 9'(qap_pkg::MaxFacilities)) ? (IB+1)'(qap_pkg::MaxFacilities)
                                                    : size_ff[IB:0];
   end

   assign ai = a_ff;
   assign bi = b_ff;
   assign li = loc_ff[ai];
   assign lj = loc_ff[bi];
   assign lk = loc_ff[cmd.k];
   assign lk2 = loc_ff[cmd.k2];

   // Address selection for a term f(x,y) * (d(p,q) - d(r,s)), or f(x,y) * d(p,q) for a full-cost term.
   always_comb begin
      fa = '0; da_a = '0; db_a = '0;
      if (cmd.full_term) begin
         fa = {cmd.k, cmd.k2};
         da_a = {lk, lk2};
      end else begin
         case (cmd.kind)
            qap_pkg::TK_II: begin fa = {ai, ai}; da_a = {lj, lj}; db_a = {li, li}; end
            qap_pkg::TK_JJ: begin fa = {bi, bi}; da_a = {li, li}; db_a = {lj, lj}; end
            qap_pkg::TK_IJ: begin fa = {ai, bi}; da_a = {lj, li}; db_a = {li, lj}; end
            qap_pkg::TK_JI: begin fa = {bi, ai}; da_a = {li, lj}; db_a = {lj, li}; end
            qap_pkg::TK_IK: begin fa = {ai, cmd.k}; da_a = {lj, lk}; db_a = {li, lk}; end
            qap_pkg::TK_KI: begin fa = {cmd.k, ai}; da_a = {lk, lj}; db_a = {lk, li}; end
            qap_pkg::TK_JK: begin fa = {bi, cmd.k}; da_a = {li, lk}; db_a = {lj, lk}; end
            qap_pkg::TK_KJ: begin fa = {cmd.k, bi}; da_a = {lk, li}; db_a = {lk, lj}; end
            default: begin fa = '0; da_a = '0; db_a = '0; end
         endcase
      end
   end

   // Memories: one write port, registered reads. The distance store is held twice
   // so that both distances of a term are read in the same cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr_flow) begin
         flow_mem[{ai, bi}] <= val_ff;
      end
      if (cmd.wr_dist) begin
         dist_mem_a[{ai, bi}] <= val_ff;
         dist_mem_b[{ai, bi}] <= val_ff;
      end
      f_q <= flow_mem[fa];
      da_q <= dist_mem_a[da_a];
      db_q <= dist_mem_b[db_a];
   end

   always_comb begin
      for (int x = 0; x < qap_pkg::MaxFacilities; x++) begin
         loc_in[x] = loc_ff[x];
      end
      if (cmd.wr_loc) begin
         loc_in[ai] = bi;
      end else if (cmd.swap_loc) begin
         loc_in[ai] = lj;
         loc_in[bi] = li;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int x = 0; x < qap_pkg::MaxFacilities; x++) begin
            loc_ff[x] <= IB'(x);
         end
      end else begin
         for (int x = 0; x < qap_pkg::MaxFacilities; x++) begin
            loc_ff[x] <= loc_ff[x] == loc_in[x] ? loc_ff[x] : loc_in[x];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         a_ff <= req_first_index[IB-1:0];
         b_ff <= req_second_index[IB-1:0];
         val_ff <= req_entry_value;
         oor_ff <= ({1'b0, req_first_index} >= 9'(n_w)) ||
                   ({1'b0, req_second_index} >= 9'(n_w));
      end
      pa_ff <= f_q * da_q;
      pb_ff <= f_q * db_q;
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clr_acc) begin
         acc_in = '0;
      end else if (mul_v_ff) begin
         if (mul_full_ff) begin
            acc_in = acc_ff + CB'(pa_ff);
         end else begin
            acc_in = acc_ff + CB'(pa_ff) - CB'(pb_ff);
         end
      end
      cost_in = cost_ff;
      if (cmd.add_delta) begin
         cost_in = cost_ff + acc_ff;
      end else if (cmd.set_cost) begin
         cost_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
         cost_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.issue;
         mul_v_ff <= rd_v_ff;
         cost_ff <= cost_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_full_ff <= cmd.full_term;
      mul_full_ff <= rd_full_ff;
      acc_ff <= acc_in;
      if (cmd.emit) begin
         rsp_delta_ff <= cmd.zero_delta ? '0 : acc_ff;
         rsp_cost_ff <= cost_in;
         rsp_status_ff <= cmd.bad;
      end
   end

   assign stat.mode = mode_ff;
   assign stat.out_of_range = oor_ff;
   assign stat.rsp_busy = rsp_valid_ff && rsp_stall;
   assign stat.pipe_empty = !rd_v_ff && !mul_v_ff;
   assign stat.first = ai;
   assign stat.second = bi;
   assign stat.live_n = n_w;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cost_delta = signed'(rsp_delta_ff[47:0]);
   assign rsp_total_cost = rsp_cost_ff[47:0];
   assign rsp_status = rsp_status_ff;

endmodule

FILE: rtl/qap_control.sv
module qap_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  qap_pkg::status_type  stat,
   output qap_pkg::cmd_type     cmd,
   output logic                 idle
);

   localparam int IB = qap_pkg::IdxBits;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_PAIR = 3'd2;
   localparam logic [2:0] ST_THIRD = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [IB:0]   k_ff, k_in;
   logic [IB:0]   k2_ff, k2_in;
   logic [2:0]    kind_ff, kind_in;
   logic [1:0]    drain_ff, drain_in;

   logic          skip_k;
   logic [IB:0]   k_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign idle = (state_ff == ST_IDLE);
   assign skip_k = (k_ff[IB-1:0] == stat.first) || (k_ff[IB-1:0] == stat.second);
   assign k_next = k_ff + 1'b1;

   always_comb begin
      cmd = '0;
      cmd.k = k_ff[IB-1:0];
      cmd.k2 = k2_ff[IB-1:0];
      cmd.kind = kind_ff;
      state_in = state_ff;
      k_in = k_ff;
      k2_in = k2_ff;
      kind_in = kind_ff;
      drain_in = drain_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.clr_acc = 1'b1;
            k_in = '0;
            k2_in = '0;
            kind_in = qap_pkg::TK_II;
            if (stat.mode <= qap_pkg::MODE_APPLY && stat.out_of_range) begin
               cmd.emit = 1'b1;
               cmd.bad = 1'b1;
               cmd.zero_delta = 1'b1;
               state_in = ST_FINISH;
            end else begin
               case (stat.mode)
                  qap_pkg::MODE_EVAL, qap_pkg::MODE_APPLY: state_in = ST_PAIR;
                  qap_pkg::MODE_RECOMP: begin
                     // An empty instance costs nothing, so no term is read.
                     if (stat.live_n == '0) begin
                        state_in = ST_DRAIN;
                        drain_in = '0;
                     end else begin
                        state_in = ST_FULL;
                     end
                  end
                  default: begin
                     cmd.wr_flow = (stat.mode == qap_pkg::MODE_WR_FLOW);
                     cmd.wr_dist = (stat.mode == qap_pkg::MODE_WR_DIST);
                     cmd.wr_loc = (stat.mode == qap_pkg::MODE_ASSIGN);
                     cmd.emit = 1'b1;
                     cmd.zero_delta = 1'b1;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_PAIR: begin
            // Diagonal and cross terms of the two swapped facilities.
            cmd.issue = (stat.first != stat.second);
            if (kind_ff == qap_pkg::TK_JI) begin
               kind_in = qap_pkg::TK_IK;
               state_in = ST_THIRD;
            end else begin
               kind_in = kind_ff + 1'b1;
            end
         end
         ST_THIRD: begin
            // Four terms per third facility, one per cycle.
            cmd.issue = !skip_k && (k_ff < stat.live_n);
            if (kind_ff == qap_pkg::TK_KJ || skip_k) begin
               kind_in = qap_pkg::TK_IK;
               k_in = k_next;
               if (k_next >= stat.live_n) begin
                  cmd.issue = !skip_k;
                  state_in = ST_DRAIN;
                  drain_in = '0;
               end
            end else begin
               kind_in = kind_ff + 1'b1;
            end
            if (stat.first == stat.second) begin
               cmd.issue = 1'b0;
            end
         end
         ST_FULL: begin
            cmd.issue = 1'b1;
            cmd.full_term = 1'b1;
            k2_in = k2_ff + 1'b1;
            if (k2_in >= stat.live_n) begin
               k2_in = '0;
               k_in = k_next;
               if (k_next >= stat.live_n) begin
                  state_in = ST_DRAIN;
                  drain_in = '0;
               end
            end
         end
         ST_DRAIN: begin
            if (stat.pipe_empty && drain_ff != 2'd0 && !stat.rsp_busy) begin
               cmd.emit = 1'b1;
               cmd.add_delta = (stat.mode == qap_pkg::MODE_APPLY);
               cmd.swap_loc = (stat.mode == qap_pkg::MODE_APPLY);
               cmd.set_cost = (stat.mode == qap_pkg::MODE_RECOMP);
               cmd.zero_delta = (stat.mode == qap_pkg::MODE_RECOMP);
               state_in = ST_FINISH;
            end else if (drain_ff != 2'd3) begin
               drain_in = drain_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // Hold an immediate result until the output register is free.
      if (state_ff == ST_DECODE && cmd.emit && stat.rsp_busy) begin
         cmd = '0;
         cmd.k = k_ff[IB-1:0];
         cmd.k2 = k2_ff[IB-1:0];
         cmd.kind = kind_ff;
         state_in = ST_DECODE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff <= '0;
         k2_ff <= '0;
         kind_ff <= qap_pkg::TK_II;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         k2_ff <= k2_in;
         kind_ff <= kind_in;
         drain_ff <= drain_in;
      end
   end

endmodule

FILE: rtl/qap_swap_delta_engine.sv
// Accepted request to registered result: writes, assignments, unused modes and rejected
// requests are answered from decode; an evaluate or apply swap streams its terms through
// read, multiply, accumulate (one term a cycle); a cost recompute streams all n*n products.
// n is the live size. One request at a time: the next is taken only after the result is
// registered, and later still while a result waits at the output.
// Synchronous reset: identity assignment, cost zero, size 32; matrices unset.
module qap_swap_delta_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_mode,
   input  logic [7:0]            req_first_index,
   input  logic [7:0]            req_second_index,
   input  logic [15:0]           req_entry_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [47:0]    rsp_cost_delta,
   output logic [47:0]           rsp_total_cost,
   output logic                  rsp_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [8:0]            csr_instance_size
);

   qap_pkg::cmd_type    cmd;
   qap_pkg::status_type stat;
   logic                idle;
   logic [qap_pkg::SizeBits-1:0] size_ff;

   // The size is only taken while no request is being worked on.
   assign csr_ready = idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= qap_pkg::SizeBits'(32);
      end else if (csr_valid && csr_ready) begin
         size_ff <= csr_instance_size;
      end
   end

   qap_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd),
      .idle      (idle)
   );

   qap_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_entry_value  (req_entry_value),
      .size_ff          (size_ff),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_cost_delta   (rsp_cost_delta),
      .rsp_total_cost   (rsp_total_cost),
      .rsp_status       (rsp_status)
   );

endmodule

FILE: dv/qap_swap_delta_checker.sv
`timescale 1ns / 1ps

module qap_swap_delta_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [7:0]         req_first_index,
   input  logic [7:0]         req_second_index,
   input  logic [15:0]        req_entry_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [47:0] rsp_cost_delta,
   input  logic [47:0]        rsp_total_cost,
   input  logic               rsp_status,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [8:0]         csr_instance_size,
   output int                 error_count,
   output int                 pending_count
);

   typedef struct packed {
      logic [47:0] delta;
      logic [47:0] cost;
      logic        status;
   } swap_result_type;

   logic [qap_pkg::EntryBits-1:0] flow_m [qap_pkg::MaxFacilities*qap_pkg::MaxFacilities];
   logic [qap_pkg::EntryBits-1:0] dist_m [qap_pkg::MaxFacilities*qap_pkg::MaxFacilities];
   logic [qap_pkg::IdxBits-1:0]   loc_m [qap_pkg::MaxFacilities];
   logic [qap_pkg::CostBits-1:0]  cost_m;
   logic [qap_pkg::SizeBits-1:0]  size_m;
   swap_result_type               expected_q [$];

   assign pending_count = expected_q.size();

   function automatic bit [63:0] fv(int a, int b);
      return 64'(flow_m[a*qap_pkg::MaxFacilities+b]);
   endfunction

   function automatic bit [63:0] dv_(int a, int b);
      return 64'(dist_m[a*qap_pkg::MaxFacilities+b]);
   endfunction

   function automatic bit [63:0] swap_gain(int i, int j, int n);
      bit [63:0] d;
      int li, lj, lk;
      d = 0;
      li = int'(loc_m[i]);
      lj = int'(loc_m[j]);
      d += fv(i, i) * dv_(lj, lj) - fv(i, i) * dv_(li, li);
      d += fv(j, j) * dv_(li, li) - fv(j, j) * dv_(lj, lj);
      d += fv(i, j) * dv_(lj, li) - fv(i, j) * dv_(li, lj);
      d += fv(j, i) * dv_(li, lj) - fv(j, i) * dv_(lj, li);
      for (int k = 0; k < n; k++) begin
         if (k != i && k != j) begin
            lk = int'(loc_m[k]);
            d += fv(i, k) * dv_(lj, lk) - fv(i, k) * dv_(li, lk);
            d += fv(k, i) * dv_(lk, lj) - fv(k, i) * dv_(lk, li);
            d += fv(j, k) * dv_(li, lk) - fv(j, k) * dv_(lj, lk);
            d += fv(k, j) * dv_(lk, li) - fv(k, j) * dv_(lk, lj);
         end
      end
      return d;
   endfunction

   function automatic swap_result_type predict_request(logic [2:0] mode, int a, int b,
                                                       logic [15:0] v);
      swap_result_type r;
      bit [63:0] d, c;
      logic [qap_pkg::IdxBits-1:0] t;
      int n;
      n = (size_m > qap_pkg::MaxFacilities) ? qap_pkg::MaxFacilities : int'(size_m);
      r = '0;
      if (mode <= qap_pkg::MODE_APPLY && (a >= n || b >= n)) begin
         r.status = 1'b1;
      end else begin
         case (mode)
            qap_pkg::MODE_WR_FLOW: flow_m[a*qap_pkg::MaxFacilities+b] = v;
            qap_pkg::MODE_WR_DIST: dist_m[a*qap_pkg::MaxFacilities+b] = v;
            qap_pkg::MODE_ASSIGN:  loc_m[a] = qap_pkg::IdxBits'(b);
            qap_pkg::MODE_EVAL, qap_pkg::MODE_APPLY: begin
               d = swap_gain(a, b, n);
               r.delta = d[47:0];
               if (mode == qap_pkg::MODE_APPLY) begin
                  t = loc_m[a];
                  loc_m[a] = loc_m[b];
                  loc_m[b] = t;
                  cost_m = cost_m + d[47:0];
               end
            end
            qap_pkg::MODE_RECOMP: begin
               c = 0;
               for (int x = 0; x < n; x++)
                  for (int y = 0; y < n; y++)
                     c += fv(x, y) * dv_(int'(loc_m[x]), int'(loc_m[y]));
               cost_m = c[47:0];
            end
            default: ;
         endcase
      end
      r.cost = cost_m;
      return r;
   endfunction

   always @(posedge clock) begin
      swap_result_type got, want, predicted;
      if (reset) begin
         for (int f = 0; f < qap_pkg::MaxFacilities; f++) loc_m[f] = qap_pkg::IdxBits'(f);
         cost_m = '0;
         size_m = qap_pkg::SizeBits'(32);
         expected_q.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) size_m = csr_instance_size;
         if (req_valid && !req_stall) begin
            predicted = predict_request(req_mode, int'(req_first_index),
                                        int'(req_second_index), req_entry_value);
            expected_q = {expected_q, predicted};
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_cost_delta, rsp_total_cost, rsp_status};
            if (expected_q.size() == 0) begin
               $error("result with no request outstanding");
               error_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.delta !== want.delta) begin
                  $error("cost_delta expected %0d actual %0d",
                         $signed(want.delta), $signed(got.delta));
                  error_count++;
               end
               if (got.cost !== want.cost) begin
                  $error("total_cost expected %0d actual %0d", want.cost, got.cost);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  error_count++;
               end
            end
         end
      end
   end

endmodule

FILE: dv/qap_swap_delta_engine_tb.sv
`timescale 1ns / 1ps

module qap_swap_delta_engine_tb;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_mode = '0;
   logic [7:0]         req_first_index = '0;
   logic [7:0]         req_second_index = '0;
   logic [15:0]        req_entry_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic signed [47:0] rsp_cost_delta;
   logic [47:0]        rsp_total_cost;
   logic               rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [8:0]         csr_instance_size = 9'd32;
   int                 error_count;
   int                 pending_count;
   int                 live_n = 32;
   logic               req_taken, rsp_taken, csr_taken;

   qap_swap_delta_engine dut (.*);

   qap_swap_delta_checker chk (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Outputs only move at the rising edge, so sampling at the falling edge
   // tells what the next rising edge will accept.
   always @(negedge clock) begin
      req_taken <= req_valid && !req_stall;
      rsp_taken <= rsp_valid && !rsp_stall;
      csr_taken <= csr_valid && csr_ready;
   end

   task automatic send_request(logic [2:0] mode, logic [7:0] a, logic [7:0] b,
                               logic [15:0] v);
      int gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode <= mode;
      req_first_index <= a;
      req_second_index <= b;
      req_entry_value <= v;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_taken);
   endtask

   task automatic drain_and_size(logic [8:0] size);
      req_valid <= 1'b0;
      // This wait lets the checker log the request taken at the last edge.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_instance_size <= size;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
      live_n = (size > 32) ? 32 : int'(size);
   endtask

   function automatic logic [7:0] pick_index();
      if (live_n == 0 || $urandom_range(0, 19) == 0) return 8'($urandom);
      return 8'($urandom_range(0, live_n - 1));
   endfunction

   task automatic random_phase(int count);
      int r;
      logic [2:0] mode;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35) mode = qap_pkg::MODE_EVAL;
         else if (r < 65) mode = qap_pkg::MODE_APPLY;
         else if (r < 73) mode = qap_pkg::MODE_ASSIGN;
         else if (r < 83) mode = qap_pkg::MODE_WR_FLOW;
         else if (r < 93) mode = qap_pkg::MODE_WR_DIST;
         else if (r < 97) mode = qap_pkg::MODE_RECOMP;
         else mode = 3'($urandom_range(6, 7));
         send_request(mode, pick_index(), pick_index(), 16'($urandom));
      end
   endtask

   // Receiver: a random stall per result, with one long hold-off to back the
   // block up into its request side.
   initial begin
      int wait_cycles;
      int results;
      results = 0;
      @(negedge reset);
      forever begin
         wait_cycles = $urandom_range(0, 12);
         if (results % 97 > 60) wait_cycles = 0;
         if (results == 500) wait_cycles = 400;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_taken);
         results++;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Every matrix entry is written before any swap or recompute reads it.
      for (int a = 0; a < 32; a++)
         for (int b = 0; b < 32; b++) begin
            send_request(qap_pkg::MODE_WR_FLOW, 8'(a), 8'(b),
                         (a == b) ? 16'hFFFF : 16'($urandom));
            send_request(qap_pkg::MODE_WR_DIST, 8'(a), 8'(b),
                         (a == 1) ? 16'h0000 : 16'($urandom));
         end
      send_request(qap_pkg::MODE_RECOMP, 8'd0, 8'd0, 16'h0000);
      send_request(qap_pkg::MODE_EVAL, 8'd0, 8'd31, 16'h0000);
      send_request(qap_pkg::MODE_APPLY, 8'd0, 8'd31, 16'hFFFF);
      send_request(qap_pkg::MODE_EVAL, 8'd5, 8'd5, 16'h0000);
      send_request(qap_pkg::MODE_APPLY, 8'd7, 8'd7, 16'h0000);
      send_request(qap_pkg::MODE_EVAL, 8'd255, 8'd3, 16'h0000);
      send_request(qap_pkg::MODE_APPLY, 8'd3, 8'd32, 16'h0000);
      send_request(qap_pkg::MODE_WR_FLOW, 8'd32, 8'd0, 16'hFFFF);
      send_request(qap_pkg::MODE_WR_DIST, 8'd0, 8'd255, 16'hFFFF);
      send_request(qap_pkg::MODE_ASSIGN, 8'd255, 8'd0, 16'h0000);
      // Two facilities on one location; the recompute sums the duplicate.
      send_request(qap_pkg::MODE_ASSIGN, 8'd2, 8'd9, 16'h0000);
      send_request(qap_pkg::MODE_EVAL, 8'd2, 8'd9, 16'h0000);
      send_request(qap_pkg::MODE_RECOMP, 8'd0, 8'd0, 16'h0000);
      send_request(qap_pkg::MODE_ASSIGN, 8'd2, 8'd2, 16'h0000);
      send_request(qap_pkg::MODE_RECOMP, 8'd0, 8'd0, 16'h0000);
      send_request(3'd6, 8'hFF, 8'hFF, 16'hFFFF);
      send_request(3'd7, 8'h00, 8'h00, 16'h0000);
      send_request(qap_pkg::MODE_APPLY, 8'd31, 8'd30, 16'h0000);
      drain_and_size(9'd2);
      send_request(qap_pkg::MODE_APPLY, 8'd0, 8'd1, 16'h0000);
      send_request(qap_pkg::MODE_EVAL, 8'd1, 8'd2, 16'h0000);
      random_phase(40);
      drain_and_size(9'd0);
      send_request(qap_pkg::MODE_RECOMP, 8'd0, 8'd0, 16'h0000);
      random_phase(20);
      drain_and_size(9'd511);
      random_phase(40);
      drain_and_size(9'd256);
      random_phase(30);
      drain_and_size(9'd7);
      random_phase(40);
      drain_and_size(9'd32);
      random_phase(80);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("PASS qap_swap_delta_engine");
      end else begin
         $display("FAIL qap_swap_delta_engine");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("FAIL qap_swap_delta_engine");
      $finish;
   end

endmodule

FILE: files.f
rtl/qap_pkg.sv
rtl/qap_datapath.sv
rtl/qap_control.sv
rtl/qap_swap_delta_engine.sv
dv/qap_swap_delta_checker.sv
dv/qap_swap_delta_engine_tb.sv
